[sv/multilevel_priority_scheduler_assert.svh]
// Assertion macros used by the scheduler top level.
`ifndef MULTILEVEL_PRIORITY_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_PRIORITY_SCHEDULER_ASSERT_SVH

// Check a property on the rising clock edge, muted while reset is active.
`define MLPS_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define MLPS_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/mlps_pkg.sv]
`timescale 1ns / 1ps
package mlps_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int TICKET_MAX     = 255;
	localparam int LVL_W          = 3;
	localparam int AGE_W          = 16;
	localparam int SEED_W         = 31;
	localparam int CFG_IDX_W      = 1;

	localparam logic [SEED_W-1:0] LCG_MUL  = 31'd1103515245;
	localparam logic [SEED_W-1:0] LCG_ADD  = 31'd12345;
	localparam int                DRAW_MOD = 201;

	localparam logic [AGE_W-1:0] TH2_RESET = 16'd50;
	localparam logic [AGE_W-1:0] TH3_RESET = 16'd100;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TH2 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TH3 = 1'b1;

	// item kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_RUN  = 2'd1;
	localparam logic [1:0] KIND_PRIO = 2'd2;
	localparam logic [1:0] KIND_PICK = 2'd3;

	// result status
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	// scan modes
	localparam logic [1:0] MODE_FIND  = 2'd0;
	localparam logic [1:0] MODE_ROUND = 2'd1;
	localparam logic [1:0] MODE_DRAW  = 2'd2;

	localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;
	localparam logic [LVL_W-1:0] LVL_SJF  = 3'd1;
	localparam logic [LVL_W-1:0] LVL_IDX  = 3'd2;
	localparam logic [LVL_W-1:0] LVL_LOT  = 3'd3;
	localparam logic [LVL_W-1:0] LVL_FCFS = 3'd4;

	typedef struct packed {
		logic       capture;
		logic       do_load;
		logic       do_run;
		logic       rd_item;
		logic       do_prio;
		logic       scan_clr;
		logic       find_clr;
		logic       scan_run;
		logic [1:0] mode;
		logic       seed_step;
		logic       div_start;
		logic       div_sel;
		logic       sel_cand;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic             scan_done;
		logic [LVL_W-1:0] best_lvl;
		logic             tot_zero;
		logic             div_done;
		logic             drew;
		logic [1:0]       kind;
		logic [LVL_W-1:0] prio;
		logic             slot_ok;
	} stat_t;

endpackage

[sv/mlps_div.sv]
`timescale 1ns / 1ps
module mlps_div #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 16,
	localparam int CNT_W = $clog2(DVD_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVS_W-1:0] rem
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// one restoring step per cycle
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[sv/mlps_dp.sv]
`timescale 1ns / 1ps
module mlps_dp import mlps_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	localparam int SLOT_W = $clog2(SLOT_COUNT),
	localparam int CNT_W = $clog2(SLOT_COUNT + 1),
	localparam int TOT_W = $clog2(SLOT_COUNT * TICKET_MAX + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AGE_W-1:0]     cfg_data,
	input  logic [1:0]           kind,
	input  logic [5:0]           slot,
	input  logic                 runnable,
	input  logic [2:0]           priority_req,
	input  logic [7:0]           tickets,
	input  logic [7:0]           job_length,
	input  logic [31:0]          arrival_time,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic [SLOT_W-1:0]    pick_slot
);

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [AGE_W-1:0] aging;
	} attr_t;

	typedef struct packed {
		logic [7:0]  tickets;
		logic [7:0]  length;
		logic [31:0] arrival;
	} sdata_t;

	logic [AGE_W-1:0] th2_q, th3_q;

	logic [1:0]  kind_q;
	logic [5:0]  slot_q;
	logic        run_q;
	logic [2:0]  prio_q;
	logic [7:0]  tick_q;
	logic [7:0]  len_q;
	logic [31:0] arr_q;
	logic [SLOT_W-1:0] slot_ix;
	logic        slot_ok;

	attr_t  attr_mem [SLOT_COUNT];
	sdata_t data_mem [SLOT_COUNT];

	logic [SLOT_COUNT-1:0] ready_q, pend_q, avld_q;

	logic [CNT_W-1:0]  idx_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	attr_t             attr_s1;
	sdata_t            data_s1;
	logic              avld_s1;
	logic [SLOT_W-1:0] rd_addr;
	logic              issue;

	logic [LVL_W-1:0]  lvl_s1;
	logic [AGE_W-1:0]  ag_s1;
	logic              elig;

	logic              attr_we;
	logic [SLOT_W-1:0] attr_wa;
	attr_t             attr_wd;

	logic [AGE_W-1:0]  age_inc;
	attr_t             aged;

	logic [LVL_W-1:0]  best_q;
	logic              c4f_q, c3f_q, c2f_q, c1f_q;
	logic [SLOT_W-1:0] c4ix_q, c3ix_q, c2ix_q, c1ix_q;
	logic [31:0]       c4arr_q;
	logic [7:0]        c1len_q;
	logic [TOT_W-1:0]  total_q;

	logic [TOT_W-1:0]  acc_q, acc_n;
	logic              drew_q;
	logic [SLOT_W-1:0] pick_q;

	logic [SEED_W-1:0]   seed_q;
	logic [2*SEED_W-1:0] prod;
	logic [SEED_W-1:0]   dvd;
	logic [TOT_W-1:0]    dvs;
	logic [TOT_W-1:0]    win;
	logic                div_done;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th2_q <= TH2_RESET;
			th3_q <= TH3_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TH2: th2_q <= cfg_data;
				CFG_TH3: th3_q <= cfg_data;
			endcase
		end
	end

	// hold the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			slot_q <= slot;
			run_q  <= runnable;
			prio_q <= priority_req;
			tick_q <= tickets;
			len_q  <= job_length;
			arr_q  <= arrival_time;
		end
	end

	assign slot_ix = SLOT_W'(slot_q);
	assign slot_ok = {26'd0, slot_q} < 32'(SLOT_COUNT);

	// slot scan address and stage one
	assign issue   = cmd.scan_run && (idx_q < CNT_W'(SLOT_COUNT));
	assign rd_addr = cmd.rd_item ? slot_ix : idx_q[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_clr) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue)
				idx_q <= idx_q + 1'b1;
		end
	end

	// slot memories
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q[SLOT_W-1:0];
		attr_s1 <= attr_mem[rd_addr];
		data_s1 <= data_mem[rd_addr];
		avld_s1 <= avld_q[rd_addr];
		if (attr_we)
			attr_mem[attr_wa] <= attr_wd;
		if (cmd.do_load)
			data_mem[slot_ix] <= '{tickets: tick_q, length: len_q, arrival: arr_q};
	end

	assign lvl_s1 = avld_s1 ? attr_s1.level : LVL_NONE;
	assign ag_s1  = avld_s1 ? attr_s1.aging : '0;
	assign elig   = vld_s1 && pend_q[idx_s1] && ready_q[idx_s1] &&
	                lvl_s1 >= LVL_SJF && lvl_s1 <= LVL_FCFS;

	// aging and promotion for a new round
	always_comb begin
		age_inc = (ag_s1 == '1) ? ag_s1 : ag_s1 + 1'b1;
		aged    = '{level: lvl_s1, aging: age_inc};
		if (age_inc >= th3_q) begin
			if (lvl_s1 == LVL_LOT)
				aged = '{level: LVL_FCFS, aging: '0};
		end else if (age_inc >= th2_q) begin
			if (lvl_s1 == LVL_IDX)
				aged = '{level: LVL_LOT, aging: '0};
		end
	end

	// attribute write port
	always_comb begin
		attr_we = 1'b0;
		attr_wa = slot_ix;
		attr_wd = '{level: prio_q, aging: '0};
		if (cmd.do_load) begin
			attr_we = 1'b1;
		end else if (cmd.do_prio) begin
			attr_we = 1'b1;
			attr_wd = '{level: prio_q, aging: ag_s1};
		end else if (cmd.scan_run && cmd.mode == MODE_ROUND && vld_s1 && ready_q[idx_s1]) begin
			attr_we = 1'b1;
			attr_wa = idx_s1;
			attr_wd = aged;
		end
	end

	// per-slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
			pend_q  <= '0;
			avld_q  <= '0;
		end else begin
			if (attr_we)
				avld_q[attr_wa] <= 1'b1;
			if (cmd.do_load) begin
				ready_q[slot_ix] <= run_q;
				pend_q[slot_ix]  <= 1'b0;
			end
			if (cmd.do_run)
				ready_q[slot_ix] <= run_q;
			if (cmd.scan_run && cmd.mode == MODE_ROUND && vld_s1)
				pend_q[idx_s1] <= ready_q[idx_s1] &&
				                  aged.level >= LVL_SJF && aged.level <= LVL_FCFS;
			if (cmd.commit) begin
				ready_q[pick_q] <= 1'b0;
				pend_q[pick_q]  <= 1'b0;
			end
		end
	end

	// per-level candidates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= LVL_NONE;
			c4f_q   <= 1'b0;
			c3f_q   <= 1'b0;
			c2f_q   <= 1'b0;
			c1f_q   <= 1'b0;
			total_q <= '0;
		end else if (cmd.find_clr) begin
			best_q  <= LVL_NONE;
			c4f_q   <= 1'b0;
			c3f_q   <= 1'b0;
			c2f_q   <= 1'b0;
			c1f_q   <= 1'b0;
			total_q <= '0;
		end else if (cmd.scan_run && cmd.mode == MODE_FIND && elig) begin
			if (lvl_s1 > best_q)
				best_q <= lvl_s1;
			unique case (lvl_s1)
				LVL_FCFS: if (!c4f_q || data_s1.arrival < c4arr_q) c4f_q <= 1'b1;
				LVL_LOT: begin
					c3f_q   <= 1'b1;
					total_q <= total_q + TOT_W'(data_s1.tickets);
				end
				LVL_IDX: c2f_q <= 1'b1;
				default: if (!c1f_q || data_s1.length < c1len_q) c1f_q <= 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run && cmd.mode == MODE_FIND && elig) begin
			unique case (lvl_s1)
				LVL_FCFS: if (!c4f_q || data_s1.arrival < c4arr_q) begin
					c4ix_q  <= idx_s1;
					c4arr_q <= data_s1.arrival;
				end
				LVL_LOT: if (!c3f_q) c3ix_q <= idx_s1;
				LVL_IDX: if (!c2f_q) c2ix_q <= idx_s1;
				default: if (!c1f_q || data_s1.length < c1len_q) begin
					c1ix_q  <= idx_s1;
					c1len_q <= data_s1.length;
				end
			endcase
		end
	end

	// lottery walk
	assign acc_n = acc_q + TOT_W'(data_s1.tickets);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			drew_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			acc_q  <= '0;
			drew_q <= 1'b0;
		end else if (cmd.scan_run && cmd.mode == MODE_DRAW && elig &&
		             lvl_s1 == LVL_LOT && !drew_q) begin
			acc_q <= acc_n;
			if (acc_n > win)
				drew_q <= 1'b1;
		end
	end

	// chosen slot
	always_ff @(posedge clk) begin
		if (cmd.sel_cand) begin
			unique case (best_q)
				LVL_FCFS: pick_q <= c4ix_q;
				LVL_LOT:  pick_q <= c3ix_q;
				LVL_IDX:  pick_q <= c2ix_q;
				default:  pick_q <= c1ix_q;
			endcase
		end else if (cmd.scan_run && cmd.mode == MODE_DRAW && elig &&
		             lvl_s1 == LVL_LOT && !drew_q && acc_n > win) begin
			pick_q <= idx_s1;
		end
	end

	// lottery seed
	assign prod = seed_q * LCG_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= '0;
		else if (cmd.seed_step)
			seed_q <= prod[SEED_W-1:0] + LCG_ADD;
	end

	// shared remainder unit: seed by the draw modulus, then by the ticket total
	assign dvd = cmd.div_sel ? SEED_W'(win) : seed_q;
	assign dvs = cmd.div_sel ? total_q : TOT_W'(DRAW_MOD);

	mlps_div #(
		.DVD_W(SEED_W),
		.DVS_W(TOT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dvd),
		.divisor (dvs),
		.done    (div_done),
		.rem     (win)
	);

	always_comb begin
		stat.scan_done = cmd.scan_run && !issue && !vld_s1;
		stat.best_lvl  = best_q;
		stat.tot_zero  = total_q == '0;
		stat.div_done  = div_done;
		stat.drew      = drew_q;
		stat.kind      = kind_q;
		stat.prio      = prio_q;
		stat.slot_ok   = slot_ok;
	end

	assign pick_slot = pick_q;

endmodule

[sv/mlps_ctrl.sv]
`timescale 1ns / 1ps
module mlps_ctrl import mlps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_free,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       in_ready,
	output logic       res_load,
	output logic       res_valid,
	output logic [1:0] res_status
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_PRIO_WR = 4'd2;
	localparam logic [3:0] S_FIND    = 4'd3;
	localparam logic [3:0] S_ROUND   = 4'd4;
	localparam logic [3:0] S_SEED    = 4'd5;
	localparam logic [3:0] S_D1GO    = 4'd6;
	localparam logic [3:0] S_D1WT    = 4'd7;
	localparam logic [3:0] S_D2GO    = 4'd8;
	localparam logic [3:0] S_D2WT    = 4'd9;
	localparam logic [3:0] S_DRAW    = 4'd10;
	localparam logic [3:0] S_COMMIT  = 4'd11;
	localparam logic [3:0] S_RESULT  = 4'd12;

	logic [3:0] state_q, state_d;
	logic       rounded_q, rounded_d;
	logic       rv_q, rv_d;
	logic [1:0] rs_q, rs_d;
	logic       prio_bad;

	assign prio_bad = stat.prio == LVL_NONE || stat.prio > LVL_FCFS;

	always_comb begin
		state_d   = state_q;
		rounded_d = rounded_q;
		rv_d      = rv_q;
		rs_d      = rs_q;
		cmd       = '0;
		in_ready  = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				rv_d    = 1'b0;
				rs_d    = ST_OK;
				state_d = S_RESULT;
				unique case (stat.kind)
					KIND_LOAD: if (stat.slot_ok) begin
						if (stat.prio > LVL_FCFS)
							rs_d = ST_REJECT;
						else
							cmd.do_load = 1'b1;
					end
					KIND_RUN: cmd.do_run = stat.slot_ok;
					KIND_PRIO: if (stat.slot_ok) begin
						if (prio_bad) begin
							rs_d = ST_REJECT;
						end else begin
							cmd.rd_item = 1'b1;
							state_d     = S_PRIO_WR;
						end
					end
					KIND_PICK: begin
						cmd.scan_clr = 1'b1;
						cmd.find_clr = 1'b1;
						rounded_d    = 1'b0;
						state_d      = S_FIND;
					end
				endcase
			end
			S_PRIO_WR: begin
				cmd.do_prio = 1'b1;
				state_d     = S_RESULT;
			end
			S_FIND: begin
				cmd.scan_run = 1'b1;
				cmd.mode     = MODE_FIND;
				if (stat.scan_done) begin
					if (stat.best_lvl == LVL_NONE) begin
						if (!rounded_q) begin
							rounded_d    = 1'b1;
							cmd.scan_clr = 1'b1;
							state_d      = S_ROUND;
						end else begin
							rs_d    = ST_EMPTY;
							state_d = S_RESULT;
						end
					end else if (stat.best_lvl == LVL_LOT) begin
						state_d = S_SEED;
					end else begin
						cmd.sel_cand = 1'b1;
						state_d      = S_COMMIT;
					end
				end
			end
			S_ROUND: begin
				cmd.scan_run = 1'b1;
				cmd.mode     = MODE_ROUND;
				if (stat.scan_done) begin
					cmd.scan_clr = 1'b1;
					cmd.find_clr = 1'b1;
					state_d      = S_FIND;
				end
			end
			S_SEED: begin
				cmd.seed_step = 1'b1;
				state_d       = S_D1GO;
			end
			S_D1GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_D1WT;
			end
			S_D1WT: if (stat.div_done) begin
				if (stat.tot_zero) begin
					cmd.sel_cand = 1'b1;
					state_d      = S_COMMIT;
				end else begin
					state_d = S_D2GO;
				end
			end
			S_D2GO: begin
				cmd.div_sel   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = S_D2WT;
			end
			S_D2WT: begin
				cmd.div_sel = 1'b1;
				if (stat.div_done) begin
					cmd.scan_clr = 1'b1;
					state_d      = S_DRAW;
				end
			end
			S_DRAW: begin
				cmd.scan_run = 1'b1;
				cmd.mode     = MODE_DRAW;
				cmd.div_sel  = 1'b1;
				if (stat.scan_done) begin
					cmd.sel_cand = !stat.drew;
					state_d      = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				rv_d       = 1'b1;
				rs_d       = ST_OK;
				state_d    = S_RESULT;
			end
			S_RESULT: if (out_free) begin
				res_load = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rounded_q <= 1'b0;
			rv_q      <= 1'b0;
			rs_q      <= ST_OK;
		end else begin
			state_q   <= state_d;
			rounded_q <= rounded_d;
			rv_q      <= rv_d;
			rs_q      <= rs_d;
		end
	end

	assign res_valid  = rv_q;
	assign res_status = rs_q;

endmodule

[sv/multilevel_priority_scheduler.sv]
`timescale 1ns / 1ps
// A slot write passes DISP (a priority write also PRIO_WR) on its way to the result register.
// A pick scans the slots once to find the top level, ages the slots and scans again when a new
// round starts, and for a lottery level takes two remainders and walks the tickets.
// One item is in work at a time; the output register lets the next beat in while a result waits.
// Reset (arst_n, asynchronous, active low) clears all flags, aging, the seed and the thresholds
// to 50 and 100; there is no clearing pass.
module multilevel_priority_scheduler import mlps_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AGE_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// slot[5:0], runnable[6], priority_req[9:7], tickets[17:10], job_length[25:18],
	// arrival_time[57:26], zero[63:58]
	input  logic [63:0]          s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// picked_valid[0], picked_slot[6:1], status[8:7], zero[15:9]
	output logic [15:0]          m_axis_tdata
);

	`include "multilevel_priority_scheduler_assert.svh"

	localparam int SLOT_W = $clog2(SLOT_COUNT);

	cmd_t              cmd;
	stat_t             stat;
	logic [SLOT_W-1:0] pick_slot;
	logic              out_free;
	logic              res_load;
	logic              res_valid;
	logic [1:0]        res_status;
	logic              out_vld_q;
	logic [15:0]       out_data_q;

	mlps_dp #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (s_axis_tuser),
		.slot        (s_axis_tdata[5:0]),
		.runnable    (s_axis_tdata[6]),
		.priority_req(s_axis_tdata[9:7]),
		.tickets     (s_axis_tdata[17:10]),
		.job_length  (s_axis_tdata[25:18]),
		.arrival_time(s_axis_tdata[57:26]),
		.cmd         (cmd),
		.stat        (stat),
		.pick_slot   (pick_slot)
	);

	mlps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_free  (out_free),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (s_axis_tready),
		.res_load  (res_load),
		.res_valid (res_valid),
		.res_status(res_status)
	);

	// output register
	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (res_load)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			out_data_q <= {7'd0, res_status, res_valid ? 6'(pick_slot) : 6'd0, res_valid};
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	`MLPS_CHECK(a_one_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "beat taken while busy")
	`MLPS_CHECK(a_load_free, res_load |-> (!out_vld_q || m_axis_tready), "result overwrote a waiting beat")
	`MLPS_NEVER(a_status_pick, m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[8:7] != ST_OK, "pick with bad status")

endmodule

[tb/sv/tb_multilevel_priority_scheduler.sv]
`timescale 1ns / 1ps
module tb_multilevel_priority_scheduler;
	import mlps_pkg::*;

	localparam int NSLOT      = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_LEN   = 400;
	localparam int PHASE_LEN  = 220;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [AGE_W-1:0]     cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;

	multilevel_priority_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// scheduler mirror state
	bit                 ready_m [NSLOT];
	logic [LVL_W-1:0]   level_m [NSLOT];
	bit [7:0]           tickets_m [NSLOT];
	bit [7:0]           length_m [NSLOT];
	bit [31:0]          arrival_m [NSLOT];
	bit [AGE_W-1:0]     aging_m [NSLOT];
	bit                 pending_m [NSLOT];
	bit [SEED_W-1:0]    seed_m;
	bit [AGE_W-1:0]     th2_m, th3_m;
	bit                 loaded [NSLOT];

	typedef struct {
		bit        typed;
		bit [15:0] res;
	} beat_tag_t;

	typedef struct {
		logic [1:0] kind;
		int         slot, run, prio, tk, len;
		bit [31:0]  arr;
		bit         typed;
		logic [1:0] st;
	} dir_row_t;

	bit [15:0]  pick_results_q [$];
	beat_tag_t  beat_tags_q [$];
	dir_row_t   dir_rows [$];

	int  errors, mismatches, idle_cycles;
	int  n_items, n_picked, n_empty, n_reject, n_promote;
	bit  hold_req, no_idle;

	// clock
	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic bit eligible(int i);
		return pending_m[i] && ready_m[i] && level_m[i] >= 1 && level_m[i] <= 4;
	endfunction

	function automatic int top_level();
		int best;
		best = 0;
		for (int i = 0; i < NSLOT; i++)
			if (eligible(i) && level_m[i] > best)
				best = level_m[i];
		return best;
	endfunction

	// age runnable slots, promote, and open a new round
	task start_round();
		for (int i = 0; i < NSLOT; i++) begin
			if (ready_m[i]) begin
				if (aging_m[i] != 16'hFFFF)
					aging_m[i]++;
				if (aging_m[i] >= th3_m) begin
					if (level_m[i] == LVL_LOT) begin
						level_m[i] = LVL_FCFS;
						aging_m[i] = 0;
						n_promote++;
					end
				end else if (aging_m[i] >= th2_m) begin
					if (level_m[i] == LVL_IDX) begin
						level_m[i] = LVL_LOT;
						aging_m[i] = 0;
						n_promote++;
					end
				end
			end
			pending_m[i] = ready_m[i] && level_m[i] >= 1 && level_m[i] <= 4;
		end
	endtask

	function automatic int pick_slot(int lvl);
		int        sel;
		bit [31:0] total, win, acc;
		bit [63:0] prod;
		sel = -1;
		if (lvl == LVL_LOT) begin
			total = 0;
			for (int i = 0; i < NSLOT; i++)
				if (eligible(i) && level_m[i] == LVL_LOT) begin
					total += tickets_m[i];
					if (sel < 0)
						sel = i;
				end
			prod = 64'(seed_m) * 64'd1103515245 + 64'd12345;
			seed_m = prod[SEED_W-1:0];
			if (total == 0)
				return sel;
			win = (32'(seed_m) % DRAW_MOD) % total;
			acc = 0;
			for (int i = 0; i < NSLOT; i++)
				if (eligible(i) && level_m[i] == LVL_LOT) begin
					acc += tickets_m[i];
					if (acc > win)
						return i;
				end
			return sel;
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (!eligible(i) || level_m[i] != lvl)
				continue;
			if (sel < 0) begin
				sel = i;
				if (lvl == LVL_IDX)
					break;
			end else if (lvl == LVL_FCFS && arrival_m[i] < arrival_m[sel]) begin
				sel = i;
			end else if (lvl == LVL_SJF && length_m[i] < length_m[sel]) begin
				sel = i;
			end
		end
		return sel;
	endfunction

	// compute the result beat for one accepted item
	task predict_result(input logic [1:0] kind, input logic [63:0] d, output bit [15:0] r);
		int         s, lvl, sel;
		logic [2:0] p;
		logic [1:0] st;
		bit         v;
		s = d[5:0];
		p = d[9:7];
		st = ST_OK;
		v = 0;
		sel = 0;
		if (kind == KIND_PICK) begin
			lvl = top_level();
			if (lvl == 0) begin
				start_round();
				lvl = top_level();
			end
			sel = (lvl != 0) ? pick_slot(lvl) : -1;
			if (sel >= 0) begin
				ready_m[sel] = 0;
				pending_m[sel] = 0;
				v = 1;
				n_picked++;
			end else begin
				sel = 0;
				st = ST_EMPTY;
				n_empty++;
			end
		end else if (kind == KIND_LOAD) begin
			if (p > 4) begin
				st = ST_REJECT;
			end else begin
				ready_m[s] = d[6];
				level_m[s] = p;
				tickets_m[s] = d[17:10];
				length_m[s] = d[25:18];
				arrival_m[s] = d[57:26];
				aging_m[s] = 0;
				pending_m[s] = 0;
			end
		end else if (kind == KIND_RUN) begin
			ready_m[s] = d[6];
		end else begin
			if (p < 1 || p > 4)
				st = ST_REJECT;
			else
				level_m[s] = p;
		end
		if (st == ST_REJECT)
			n_reject++;
		r = {7'd0, st, 6'(sel), v};
	endtask

	function automatic logic [63:0] pack_item(int slot, int run, int prio, int tk, int len,
			bit [31:0] arr);
		return {6'd0, arr, 8'(len), 8'(tk), 3'(prio), 1'(run), 6'(slot)};
	endfunction

	// record each accepted input beat
	always @(posedge clk) begin
		beat_tag_t tag;
		bit [15:0] r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			tag = beat_tags_q.pop_front();
			predict_result(s_axis_tuser, s_axis_tdata, r);
			if (tag.typed)
				r = tag.res;
			pick_results_q.push_back(r);
			n_items++;
		end
	end

	// check each accepted result beat
	always @(posedge clk) begin
		bit [15:0] e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pick_results_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", m_axis_tdata);
			end else begin
				e = pick_results_q.pop_front();
				if (m_axis_tdata[0] !== e[0] || m_axis_tdata[6:1] !== e[6:1] ||
						m_axis_tdata[8:7] !== e[8:7]) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: valid %0d/%0d slot %0d/%0d status %0d/%0d (exp/got)",
							e[0], m_axis_tdata[0], e[6:1], m_axis_tdata[6:1],
							e[8:7], m_axis_tdata[8:7]);
				end
			end
		end
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("FAIL multilevel_priority_scheduler");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				m_axis_tready <= 1'b1;
				hold_req = 0;
			end else begin
				n = no_idle ? 0 : gap_len();
				if (n == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					repeat (n) @(posedge clk);
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// offer one beat and hold it until accepted
	task send_beat(input logic [1:0] kind, input logic [63:0] d, input bit typed,
			input bit [15:0] res);
		beat_tag_t tag;
		tag.typed = typed;
		tag.res = res;
		beat_tags_q.push_back(tag);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task sender_gap();
		int n;
		n = no_idle ? 0 : gap_len();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pick_results_q.size() != 0 || beat_tags_q.size() != 0)
			@(posedge clk);
	endtask

	task write_cfg(input logic [CFG_IDX_W-1:0] idx, input bit [AGE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_TH2)
			th2_m = val;
		else
			th3_m = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task add_row(input logic [1:0] kind, input int slot, run, prio, tk, len,
			input bit [31:0] arr, input bit typed, input logic [1:0] st);
		dir_row_t row;
		row.kind = kind; row.slot = slot; row.run = run; row.prio = prio;
		row.tk = tk; row.len = len; row.arr = arr; row.typed = typed; row.st = st;
		dir_rows.push_back(row);
	endtask

	// build one random item, mostly well-formed with some rejects
	task make_item(output logic [1:0] kind, output logic [63:0] d);
		int r, s, p, run, tk, len;
		bit [31:0] arr;
		r = $urandom_range(0, 99);
		s = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 11) : $urandom_range(0, 63);
		run = ($urandom_range(0, 99) < 75);
		p = 0; tk = $urandom_range(0, 255); len = $urandom_range(0, 255); arr = $urandom;
		if (r < 30) begin
			kind = KIND_LOAD;
			r = $urandom_range(0, 99);
			p = (r < 10) ? $urandom_range(5, 7) : (r < 18) ? 0 : $urandom_range(1, 4);
			tk = ($urandom_range(0, 1)) ? $urandom_range(1, 255) : $urandom_range(1, 4);
			if ($urandom_range(0, 1))
				len = $urandom_range(0, 3);
			if ($urandom_range(0, 1))
				arr = $urandom_range(0, 7);
			if (p <= 4)
				loaded[s] = 1;
		end else if (r < 40) begin
			kind = KIND_RUN;
		end else if (r < 52) begin
			kind = KIND_PRIO;
			// never give a level to a slot whose data was never written
			if (loaded[s] && $urandom_range(0, 99) < 85)
				p = $urandom_range(1, 4);
			else
				p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 7);
		end else begin
			kind = KIND_PICK;
		end
		d = pack_item(s, run, p, tk, len, arr);
	endtask

	initial begin
		logic [1:0]  kind;
		logic [63:0] d;
		dir_row_t    row;
		bit [AGE_W-1:0] th2_set [7] = '{16'd1, 16'd65535, 16'd2, 16'd5, 16'd3, 16'd50, 16'd1};
		bit [AGE_W-1:0] th3_set [7] = '{16'd1, 16'd65535, 16'd3, 16'd2, 16'd8, 16'd100, 16'd65535};

		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
		th2_m = TH2_RESET; th3_m = TH3_RESET; seed_m = '0;
		foreach (ready_m[i]) begin
			ready_m[i] = 0; level_m[i] = LVL_NONE; aging_m[i] = 0; pending_m[i] = 0;
			tickets_m[i] = 0; length_m[i] = 0; arrival_m[i] = 0; loaded[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pick, rejects, extremes, every level and tie
		add_row(KIND_PICK, 0, 0, 0, 0, 0, 0, 1, ST_EMPTY);
		add_row(KIND_LOAD, 0, 1, 7, 9, 9, 9, 1, ST_REJECT);
		add_row(KIND_LOAD, 63, 1, 4, 255, 255, 32'hFFFFFFFF, 1, ST_OK);
		add_row(KIND_LOAD, 1, 1, 4, 1, 0, 0, 1, ST_OK);
		add_row(KIND_LOAD, 2, 1, 3, 255, 7, 5, 1, ST_OK);
		add_row(KIND_LOAD, 3, 1, 3, 0, 7, 5, 1, ST_OK);
		add_row(KIND_LOAD, 4, 1, 2, 10, 7, 5, 1, ST_OK);
		add_row(KIND_LOAD, 5, 1, 2, 10, 7, 5, 1, ST_OK);
		add_row(KIND_LOAD, 6, 1, 1, 10, 9, 5, 1, ST_OK);
		add_row(KIND_LOAD, 7, 1, 1, 10, 9, 5, 1, ST_OK);
		add_row(KIND_LOAD, 8, 1, 0, 10, 1, 5, 1, ST_OK);
		add_row(KIND_LOAD, 9, 0, 1, 10, 3, 5, 1, ST_OK);
		add_row(KIND_RUN, 9, 1, 0, 0, 0, 0, 1, ST_OK);
		add_row(KIND_PRIO, 4, 0, 0, 0, 0, 0, 1, ST_REJECT);
		add_row(KIND_PRIO, 4, 0, 5, 0, 0, 0, 1, ST_REJECT);
		add_row(KIND_PRIO, 5, 0, 4, 0, 0, 0, 1, ST_OK);
		add_row(KIND_RUN, 2, 0, 0, 0, 0, 0, 1, ST_OK);
		for (int i = 0; i < 10; i++)
			add_row(KIND_PICK, 0, 0, 0, 0, 0, 0, 0, ST_OK);
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == KIND_LOAD && row.prio <= 4)
				loaded[row.slot] = 1;
			send_beat(row.kind,
				pack_item(row.slot, row.run, row.prio, row.tk, row.len, row.arr),
				row.typed, {7'd0, row.st, 7'd0});
			sender_gap();
		end

		// random phases, one threshold setting each
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			write_cfg(CFG_TH2, th2_set[ph]);
			write_cfg(CFG_TH3, th3_set[ph]);
			no_idle = (ph == 4);
			if (ph == 2)
				hold_req = 1;
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 3 && n == PHASE_LEN / 2)
					drain();
				make_item(kind, d);
				send_beat(kind, d, 0, '0);
				sender_gap();
			end
		end
		drain();
		repeat (400) @(posedge clk);

		$display("covered %0d items: %0d picks served, %0d empty picks, %0d rejects",
			n_items, n_picked, n_empty, n_reject);
		$display("aging promotions %0d over 7 threshold settings, %0d mismatches",
			n_promote, mismatches);
		if (errors == 0 && pick_results_q.size() == 0)
			$display("PASS multilevel_priority_scheduler");
		else
			$display("FAIL multilevel_priority_scheduler");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/mlps_pkg.sv
sv/mlps_div.sv
sv/mlps_dp.sv
sv/mlps_ctrl.sv
sv/multilevel_priority_scheduler.sv
tb/sv/tb_multilevel_priority_scheduler.sv
